// ----- hdl/ustt_pkg.sv -----
// Shared types and constants for the user session table.
// No dependencies; compiled before every other file in hdl/.
package ustt_pkg;

    localparam int unsigned KEY_WORD_W = 64;
    localparam int unsigned NOW_W      = 40;
    localparam int unsigned EXPIRY_W   = 41;
    localparam int unsigned USER_W     = 32;
    localparam int unsigned TTL_W      = 32;
    localparam int unsigned FUNC_W     = 2;
    localparam int unsigned STATUS_W   = 2;

    localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(24 * 3600);

    typedef enum logic [FUNC_W-1:0] {
        FN_CREATE = 2'd0,
        FN_CHECK  = 2'd1,
        FN_REMOVE = 2'd2,
        FN_UNUSED = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_EXPIRED = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CREATE,
        S_SCAN,
        S_FOUND,
        S_FETCH_LAST,
        S_MOVE,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [KEY_WORD_W-1:0] word3;
        logic [KEY_WORD_W-1:0] word2;
        logic [KEY_WORD_W-1:0] word1;
        logic [KEY_WORD_W-1:0] word0;
    } key_t;

    typedef struct packed {
        key_t              key;
        logic [EXPIRY_W-1:0] expiry;
        logic [USER_W-1:0]   owner;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// ----- hdl/ustt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ustt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hdl/user_session_table_ttl.sv -----
// Top level of the user session table with time-to-live.
// Depends on ustt_pkg and ustt_ram.
//
// Holds up to MAX_ENTRIES sessions, each a 256-bit identifier, a 41-bit expiry
// time and a 32-bit user number, in one single-port-read session memory. A
// create transaction appends an entry expiring at now plus ttl_seconds, or
// answers "table full"; check and remove search linearly from entry 0 and act
// on the first match. A check on a live entry returns its user; a check on an
// expired entry, and a remove on any found entry, delete it, copying the last
// entry into its slot unless the found entry is the last one. A create writes
// its entry in S_CREATE; a check or remove scans until a hit, decides in
// S_FOUND and, when a deletion has to move the last entry, reads it in
// S_FETCH_LAST and writes it in S_MOVE; an unused request kind goes straight
// to S_RESP. The scan reads one entry per cycle through the memory's single
// read port. One request is in flight at a time; s_ready is high only while
// the sequencer is idle, so the next request can be taken in the cycle after
// the result register loads. A result waiting in the output register does
// not block a new request, but a new result holds the sequencer until that
// register is free. The memory needs no clearing after reset: only entries
// below the live count are ever read. ttl_seconds is written through the cfg
// channel, which is always ready; write it only while no transaction is in
// flight.
module user_session_table_ttl #(
    parameter int unsigned MAX_ENTRIES = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ustt_pkg::TTL_W-1:0]          cfg_data,
    // request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ustt_pkg::FUNC_W-1:0]         s_func,
    input  logic [ustt_pkg::KEY_WORD_W-1:0]     s_id_word0,
    input  logic [ustt_pkg::KEY_WORD_W-1:0]     s_id_word1,
    input  logic [ustt_pkg::KEY_WORD_W-1:0]     s_id_word2,
    input  logic [ustt_pkg::KEY_WORD_W-1:0]     s_id_word3,
    input  logic [ustt_pkg::NOW_W-1:0]          s_now_seconds,
    input  logic signed [ustt_pkg::USER_W-1:0]  s_user_number,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ustt_pkg::STATUS_W-1:0]       m_status,
    output logic signed [ustt_pkg::USER_W-1:0]  m_user_number_out
);

    import ustt_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    // sequencer
    state_t state_reg, state_next;

    // request held for the whole transaction
    func_t               func_reg;
    key_t                key_reg;
    logic [NOW_W-1:0]    now_reg;
    logic [USER_W-1:0]   user_reg;

    // table bookkeeping
    logic [TTL_W-1:0]    ttl_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    scan_idx_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic                cmp_valid_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic [EXPIRY_W-1:0] hit_expiry_reg;
    logic [USER_W-1:0]   hit_owner_reg;

    // result waiting for the output register, and the output register itself
    status_t             res_status_reg;
    logic [USER_W-1:0]   res_user_reg;
    logic                m_valid_reg;
    status_t             m_status_reg;
    logic [USER_W-1:0]   m_user_reg;

    // memory port
    logic                mem_wr_en;
    logic [IDX_W-1:0]    mem_wr_addr;
    entry_t              mem_wr_data;
    logic [IDX_W-1:0]    mem_rd_addr;
    entry_t              mem_rd_data;

    // decoded conditions
    logic                accept;
    logic                out_free;
    logic                key_match;
    logic                scan_more;
    logic [IDX_W-1:0]    last_idx;
    logic                table_full;
    logic                still_live;
    logic [EXPIRY_W-1:0] expiry_sum;

    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign key_match  = cmp_valid_reg && (mem_rd_data.key == key_reg);
    assign scan_more  = scan_idx_reg < count_reg;
    assign last_idx   = IDX_W'(count_reg - CNT_W'(1));
    assign table_full = count_reg == CNT_MAX;
    assign still_live = hit_expiry_reg > {1'b0, now_reg};
    assign expiry_sum = {1'b0, now_reg} + EXPIRY_W'(ttl_reg);

    ustt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (func_t'(s_func))
                        FN_CREATE:           state_next = S_CREATE;
                        FN_CHECK, FN_REMOVE: state_next = S_SCAN;
                        default:             state_next = S_RESP;
                    endcase
                end
            end
            S_CREATE: state_next = S_RESP;
            S_SCAN: begin
                if (key_match) begin
                    state_next = S_FOUND;
                end else if (!scan_more) begin
                    state_next = S_RESP;
                end
            end
            S_FOUND: begin
                if (func_reg == FN_CHECK && still_live) begin
                    state_next = S_RESP;
                end else if (hit_idx_reg == last_idx) begin
                    state_next = S_RESP;
                end else begin
                    state_next = S_FETCH_LAST;
                end
            end
            S_FETCH_LAST: state_next = S_MOVE;
            S_MOVE:       state_next = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Memory port and handshake outputs.
    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = hit_idx_reg;
        mem_wr_data = mem_rd_data;
        mem_rd_addr = scan_idx_reg[IDX_W-1:0];
        case (state_reg)
            S_CREATE: begin
                mem_wr_en          = !table_full;
                mem_wr_addr        = count_reg[IDX_W-1:0];
                mem_wr_data.key    = key_reg;
                mem_wr_data.expiry = expiry_sum;
                mem_wr_data.owner  = user_reg;
            end
            S_FETCH_LAST: mem_rd_addr = last_idx;
            // last entry's data arrives now; drop it into the hole
            S_MOVE:       mem_wr_en = 1'b1;
            default:      mem_wr_en = 1'b0;
        endcase
    end

    assign s_ready           = state_reg == S_IDLE;
    assign cfg_ready         = 1'b1;
    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_user_number_out = m_user_reg;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            ttl_reg       <= TTL_RESET;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                ttl_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:   cmp_valid_reg <= 1'b0;
                S_CREATE: begin
                    if (!table_full) begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
                S_SCAN: begin
                    // a read is in flight whenever the scan advanced this cycle
                    cmp_valid_reg <= !key_match && scan_more;
                end
                S_FOUND: begin
                    if (!(func_reg == FN_CHECK && still_live) && hit_idx_reg == last_idx) begin
                        count_reg <= count_reg - CNT_W'(1);
                    end
                end
                S_MOVE:   count_reg <= count_reg - CNT_W'(1);
                default:  cmp_valid_reg <= cmp_valid_reg;
            endcase
            if (state_reg == S_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    func_reg       <= func_t'(s_func);
                    key_reg        <= {s_id_word3, s_id_word2, s_id_word1, s_id_word0};
                    now_reg        <= s_now_seconds;
                    user_reg       <= s_user_number;
                    scan_idx_reg   <= '0;
                    res_status_reg <= ST_MISSING;
                    res_user_reg   <= '0;
                end
            end
            S_CREATE: res_status_reg <= table_full ? ST_FULL : ST_OK;
            S_SCAN: begin
                if (key_match) begin
                    hit_idx_reg    <= cmp_idx_reg;
                    hit_expiry_reg <= mem_rd_data.expiry;
                    hit_owner_reg  <= mem_rd_data.owner;
                end else if (scan_more) begin
                    cmp_idx_reg  <= scan_idx_reg[IDX_W-1:0];
                    scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                end
            end
            S_FOUND: begin
                if (func_reg == FN_CHECK && still_live) begin
                    res_status_reg <= ST_OK;
                    res_user_reg   <= hit_owner_reg;
                end else if (func_reg == FN_CHECK) begin
                    res_status_reg <= ST_EXPIRED;
                end else begin
                    res_status_reg <= ST_OK;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_status_reg <= res_status_reg;
                    m_user_reg   <= res_user_reg;
                end
            end
            default: begin
                res_status_reg <= res_status_reg;
            end
        endcase
    end

endmodule

// ----- hdl/ustt_checker.sv -----
// Port-level checks for the user session table, bound to the top level.
// Depends on ustt_pkg and user_session_table_ttl.
module ustt_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [ustt_pkg::STATUS_W-1:0]       m_status,
    input logic signed [ustt_pkg::USER_W-1:0]  m_user_number_out
);

    import ustt_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_user_number_out))
        else $error("stalled result changed or dropped");

    // a result that is not OK carries no user
    a_user_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_user_number_out == '0)
        else $error("user number on a non-OK result");

    // ready drops after each acceptance, so only one request is in flight
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request accepted while one is in flight");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind user_session_table_ttl ustt_checker u_ustt_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_status          (m_status),
    .m_user_number_out (m_user_number_out)
);
